// ----- src/lrf_pkg.sv -----
// lrf_pkg: shared types and codes for the LRU frame replacer.
// Used by lrf_ctrl, lrf_datapath, lru_frame_replacer_unit and the testbench; depends on nothing.

package lrf_pkg;

	// Request kinds as carried on s_tuser
	typedef enum logic [1:0] {
		KIND_VICTIM = 2'd0,
		KIND_PIN    = 2'd1,
		KIND_UNPIN  = 2'd2,
		KIND_NONE   = 2'd3
	} lrf_kind_t;

	// Controller states, one-hot
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_EXEC  = 4'b1000
	} lrf_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear;   // write zero to the listed flag at the sweep address
		logic accept;  // capture the incoming request
		logic exec;    // apply the list update and load the result register
	} lrf_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clear_last;  // sweep address is at the last frame
	} lrf_status_t;

	localparam int FRAME_FIELD_W = 6;
	localparam int COUNT_FIELD_W = 7;

endpackage

// ----- src/lrf_ctrl.sv -----
// lrf_ctrl: request sequencer for the LRU frame replacer.
// Depends on lrf_pkg; drives lrf_datapath through lrf_cmd_t.

module lrf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output lrf_pkg::lrf_cmd_t    cmd,
	input  lrf_pkg::lrf_status_t status
);

	lrf_pkg::lrf_state_t state_q;
	lrf_pkg::lrf_state_t state_d;
	logic                out_valid_q;
	logic                out_free;

	assign out_free     = !out_valid_q || m_tready;
	assign s_tready     = (state_q == lrf_pkg::ST_IDLE);
	assign m_tvalid     = out_valid_q;
	assign cmd.clear    = (state_q == lrf_pkg::ST_CLEAR);
	assign cmd.accept   = s_tvalid && s_tready;
	assign cmd.exec     = (state_q == lrf_pkg::ST_EXEC) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrf_pkg::ST_CLEAR: begin
				if (status.clear_last) begin
					state_d = lrf_pkg::ST_IDLE;
				end
			end
			lrf_pkg::ST_IDLE: begin
				if (cmd.accept) begin
					state_d = lrf_pkg::ST_READ;
				end
			end
			lrf_pkg::ST_READ: begin
				state_d = lrf_pkg::ST_EXEC;
			end
			lrf_pkg::ST_EXEC: begin
				// hold until the result register can take the new result
				if (out_free) begin
					state_d = lrf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lrf_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrf_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/lrf_datapath.sv -----
// lrf_datapath: link memories, listed flags, head/tail/count and result register.
// Depends on lrf_pkg; sequenced by lrf_ctrl.

module lrf_datapath #(
	parameter int FRAMES = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lrf_pkg::lrf_cmd_t                     cmd,
	output lrf_pkg::lrf_status_t                  status,
	input  logic [1:0]                            in_kind,
	input  logic [lrf_pkg::FRAME_FIELD_W-1:0]     in_frame,
	output logic                                  out_found,
	output logic [lrf_pkg::FRAME_FIELD_W-1:0]     out_victim,
	output logic [lrf_pkg::COUNT_FIELD_W-1:0]     out_count
);

	localparam int FW = $clog2(FRAMES);
	localparam int CW = $clog2(FRAMES + 1);

	// link and flag memories; flags are swept to zero after reset
	logic [FW-1:0] next_mem [FRAMES];
	logic [FW-1:0] prev_mem [FRAMES];
	logic          flag_mem [FRAMES];

	logic [1:0]    kind_q;
	logic [FW-1:0] fidx_q;
	logic          in_range_q;
	logic [FW-1:0] head_q;
	logic [FW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [FW-1:0] clr_q;

	logic [FW-1:0] rd_addr;
	logic [FW-1:0] nx_q;
	logic [FW-1:0] pv_q;
	logic          flag_rd_q;

	logic          is_victim;
	logic          is_pin;
	logic          is_unpin;
	logic          do_unlink;
	logic          do_append;
	logic          count_zero;
	logic [CW-1:0] count_d;

	logic          next_we;
	logic [FW-1:0] next_wa;
	logic [FW-1:0] next_wd;
	logic          prev_we;
	logic [FW-1:0] prev_wa;
	logic [FW-1:0] prev_wd;
	logic          flag_we;
	logic [FW-1:0] flag_wa;
	logic          flag_wd;

	assign status.clear_last = (clr_q == FW'(FRAMES - 1));

	assign is_victim  = (kind_q == lrf_pkg::KIND_VICTIM);
	assign is_pin     = (kind_q == lrf_pkg::KIND_PIN);
	assign is_unpin   = (kind_q == lrf_pkg::KIND_UNPIN);
	assign count_zero = (count_q == '0);

	// a victim request works on the head frame, the others on the named frame
	assign rd_addr = is_victim ? head_q : fidx_q;

	assign do_unlink = (is_victim && !count_zero) || (is_pin && in_range_q && flag_rd_q);
	assign do_append = is_unpin && in_range_q && !flag_rd_q;

	always_comb begin
		count_d = count_q;
		if (do_unlink) begin
			count_d = count_q - CW'(1);
		end else if (do_append) begin
			count_d = count_q + CW'(1);
		end
	end

	always_comb begin
		next_we = 1'b0;
		next_wa = pv_q;
		next_wd = nx_q;
		prev_we = 1'b0;
		prev_wa = nx_q;
		prev_wd = pv_q;
		flag_we = 1'b0;
		flag_wa = rd_addr;
		flag_wd = 1'b0;
		if (cmd.clear) begin
			flag_we = 1'b1;
			flag_wa = clr_q;
		end else if (cmd.exec && do_unlink) begin
			// bridge the neighbors over the removed frame
			next_we = (rd_addr != head_q);
			prev_we = (rd_addr != tail_q);
			flag_we = 1'b1;
		end else if (cmd.exec && do_append) begin
			next_we = !count_zero;
			next_wa = tail_q;
			next_wd = rd_addr;
			prev_we = !count_zero;
			prev_wa = rd_addr;
			prev_wd = tail_q;
			flag_we = 1'b1;
			flag_wd = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (flag_we) begin
			flag_mem[flag_wa] <= flag_wd;
		end
		nx_q      <= next_mem[rd_addr];
		pv_q      <= prev_mem[rd_addr];
		flag_rd_q <= flag_mem[rd_addr];
	end

	// request capture and result register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q     <= in_kind;
			fidx_q     <= FW'(in_frame);
			in_range_q <= (32'(in_frame) < FRAMES);
		end
		if (cmd.exec) begin
			out_found  <= is_victim && !count_zero;
			out_victim <= (is_victim && !count_zero) ?
				lrf_pkg::FRAME_FIELD_W'(head_q) : '0;
			out_count  <= lrf_pkg::COUNT_FIELD_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + FW'(1);
			end
			if (cmd.exec && do_unlink) begin
				if (rd_addr == head_q) begin
					head_q <= nx_q;
				end
				if (rd_addr == tail_q) begin
					tail_q <= pv_q;
				end
			end else if (cmd.exec && do_append) begin
				if (count_zero) begin
					head_q <= rd_addr;
				end
				tail_q <= rd_addr;
			end
			if (cmd.exec) begin
				count_q <= count_d;
			end
		end
	end

endmodule

// ----- src/lru_frame_replacer_unit.sv -----
// lru_frame_replacer_unit: top level of the LRU frame replacer.
// Depends on lrf_pkg, lrf_ctrl and lrf_datapath.
//
// Keeps evictable frames in least-recently-unpinned order as a doubly linked
// list held in per-frame link memories.
// Request channel (s_*): s_tuser carries the kind (victim, pin, unpin) and
// s_tdata the frame number. Kind 3 and out-of-range frames leave the list
// untouched. Result channel (m_*): one result per request, with m_tuser
// flagging a successful eviction and m_tdata carrying the evicted frame and
// the count of listed frames after the request.
// Flow: an accepted request first has the link memories read into registers,
// then the list is updated and the output register loaded; the update holds
// while a result waits. One request is in flight at a time, so no new request
// is taken before the last one reaches its update. The pace is set by the
// registered read of the link memories before the neighbor writes.
// Reset: the list empties at once; the listed flags are then swept to zero,
// one frame per cycle up to the last frame, with s_tready held low.
// Stalls: a waiting result sits in the output register; the next request is
// still taken and read, and its update holds until the result is taken.

module lru_frame_replacer_unit #(
	parameter int FRAMES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [5:0] frame, [7:6] zero
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] victim_frame, [12:6] listed_count, [15:13] zero
	output logic [0:0]  m_tuser    // [0] found
);

	lrf_pkg::lrf_cmd_t    cmd;
	lrf_pkg::lrf_status_t status;

	logic                              found;
	logic [lrf_pkg::FRAME_FIELD_W-1:0] victim_frame;
	logic [lrf_pkg::COUNT_FIELD_W-1:0] listed_count;

	// sequencer: clearing sweep, capture, read, update
	lrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// list storage and result register
	lrf_datapath #(
		.FRAMES (FRAMES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_kind    (s_tuser),
		.in_frame   (s_tdata[5:0]),
		.out_found  (found),
		.out_victim (victim_frame),
		.out_count  (listed_count)
	);

	// pack the result; the top three bits pad with zeros
	assign m_tdata = {3'b000, listed_count, victim_frame};
	assign m_tuser = found;

endmodule

// ----- src/lrf_checker.sv -----
// lrf_checker: port-level checks for lru_frame_replacer_unit.
// Depends on nothing; attached to the top level by the bind below.

module lrf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request in flight: no request is taken on the edge after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken back to back");

	// a result without eviction reports frame zero
	a_no_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[5:0] == 6'd0)
		else $error("victim frame nonzero without eviction");

	// a request taken while no result waits shows no result until its read and update are done
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
		else $error("result earlier than the update");

endmodule

bind lru_frame_replacer_unit lrf_checker u_lrf_checker (.*);

// ----- verif/tb_lru_frame_replacer_unit.sv -----
`timescale 1ns / 100ps
// tb_lru_frame_replacer_unit: self-checking bench for the LRU frame replacer.
// Depends on lrf_pkg and lru_frame_replacer_unit; holds its own list model,
// a queued request driver, a result monitor and randomized flow control.

module tb_lru_frame_replacer_unit;

	localparam int NUM_FRAMES = 64;

	typedef struct {
		lrf_pkg::lrf_kind_t                kind;
		logic [lrf_pkg::FRAME_FIELD_W-1:0] frame;
	} frame_req_t;

	typedef struct {
		logic                              found;
		logic [lrf_pkg::FRAME_FIELD_W-1:0] victim_frame;
		logic [lrf_pkg::COUNT_FIELD_W-1:0] listed_count;
	} replacer_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;

	// Requests waiting to be driven, and results still owed by the block
	frame_req_t       request_backlog[$];
	replacer_result_t pending_results[$];

	// Model state: eviction order, oldest frame at index 0
	logic [lrf_pkg::FRAME_FIELD_W-1:0] lru_order[$];
	bit                                listed_map[NUM_FRAMES];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int mismatch_count = 0;

	lru_frame_replacer_unit #(.FRAMES(NUM_FRAMES)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the model list and return the result it produces.
	function automatic replacer_result_t apply_request(input frame_req_t req);
		replacer_result_t res;
		int               idx;
		res = '{found: 1'b0, victim_frame: '0, listed_count: '0};
		case (req.kind)
			lrf_pkg::KIND_VICTIM: begin
				if (lru_order.size() != 0) begin
					res.found        = 1'b1;
					res.victim_frame = lru_order[0];
					lru_order.delete(0);
					listed_map[res.victim_frame] = 1'b0;
				end
			end
			lrf_pkg::KIND_PIN: begin
				if (listed_map[req.frame]) begin
					for (idx = 0; idx < lru_order.size(); idx++)
						if (lru_order[idx] == req.frame)
							break;
					lru_order.delete(idx);
					listed_map[req.frame] = 1'b0;
				end
			end
			lrf_pkg::KIND_UNPIN: begin
				// an already listed frame keeps its place in line
				if (!listed_map[req.frame]) begin
					lru_order = {lru_order, req.frame};
					listed_map[req.frame] = 1'b1;
				end
			end
			default: ;
		endcase
		res.listed_count = lrf_pkg::COUNT_FIELD_W'(lru_order.size());
		return res;
	endfunction

	function automatic void queue_request(input lrf_pkg::lrf_kind_t kind, input int frame);
		frame_req_t req;
		req.kind        = kind;
		req.frame       = frame[lrf_pkg::FRAME_FIELD_W-1:0];
		request_backlog = {request_backlog, req};
	endfunction

	// Draw a kind from cumulative percentage thresholds; the rest go to the unused kind.
	function automatic lrf_pkg::lrf_kind_t pick_kind(input int victim_to, input int pin_to,
			input int unpin_to);
		int roll;
		roll = $urandom_range(99);
		if (roll < victim_to)
			return lrf_pkg::KIND_VICTIM;
		else if (roll < pin_to)
			return lrf_pkg::KIND_PIN;
		else if (roll < unpin_to)
			return lrf_pkg::KIND_UNPIN;
		return lrf_pkg::KIND_NONE;
	endfunction

	// Build random traffic as episodes: fill the list, churn it, drain it past empty.
	task automatic add_random_requests(input int count);
		int                                added;
		int                                i;
		int                                j;
		logic [lrf_pkg::FRAME_FIELD_W-1:0] perm[NUM_FRAMES];
		logic [lrf_pkg::FRAME_FIELD_W-1:0] swap;
		added = 0;
		while (added < count) begin
			case ($urandom_range(2))
				0: begin
					for (i = 0; i < NUM_FRAMES; i++)
						perm[i] = lrf_pkg::FRAME_FIELD_W'(i);
					for (i = NUM_FRAMES - 1; i > 0; i--) begin
						j       = $urandom_range(i);
						swap    = perm[i];
						perm[i] = perm[j];
						perm[j] = swap;
					end
					for (i = 0; i < NUM_FRAMES; i++) begin
						queue_request(lrf_pkg::KIND_UNPIN, perm[i]);
						added++;
						if ($urandom_range(7) == 0) begin
							queue_request(pick_kind(30, 55, 95), $urandom_range(63));
							added++;
						end
					end
				end
				1: begin
					for (i = 0; i < 60; i++)
						queue_request(pick_kind(30, 55, 95), $urandom_range(63));
					added += 60;
				end
				default: begin
					for (i = 0; i < 80; i++)
						queue_request(pick_kind(70, 88, 96), $urandom_range(63));
					added += 80;
				end
			endcase
		end
	endtask

	task automatic drain_backlog();
		while (request_backlog.size() != 0)
			@(negedge clk);
	endtask

	// Request driver: predict on acceptance, then offer the next backlog entry
	// unless this cycle idles.
	always @(posedge clk) begin
		frame_req_t taken;
		logic       offering;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			offering = s_tvalid;
			if (s_tvalid && s_tready) begin
				taken.kind      = lrf_pkg::lrf_kind_t'(s_tuser);
				taken.frame     = s_tdata[lrf_pkg::FRAME_FIELD_W-1:0];
				pending_results = {pending_results, apply_request(taken)};
				offering        = 1'b0;
			end
			if (!offering) begin
				if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					taken = request_backlog[0];
					request_backlog.delete(0);
					s_tvalid <= 1'b1;
					s_tuser  <= taken.kind;
					s_tdata  <= {2'b00, taken.frame};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result ready: a pending hold-off wins over the random stall
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Result monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		replacer_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("[%0t] unexpected result: found=%0d victim=%0d count=%0d",
						$realtime, m_tuser[0], m_tdata[5:0], m_tdata[12:6]);
				mismatch_count++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (m_tuser[0] !== want.found || m_tdata[5:0] !== want.victim_frame ||
						m_tdata[12:6] !== want.listed_count) begin
					// fields in order: found, victim frame, listed count
					if (mismatch_count < 10)
						$display("[%0t] mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							$realtime, want.found, want.victim_frame, want.listed_count,
							m_tuser[0], m_tdata[5:0], m_tdata[12:6]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty list, head, middle and tail removal, repeat unpin,
		// unused kind and both frame extremes.
		queue_request(lrf_pkg::KIND_VICTIM, 0);
		queue_request(lrf_pkg::KIND_PIN, 5);
		queue_request(lrf_pkg::KIND_UNPIN, 0);
		queue_request(lrf_pkg::KIND_UNPIN, 63);
		queue_request(lrf_pkg::KIND_UNPIN, 0);
		queue_request(lrf_pkg::KIND_UNPIN, 21);
		queue_request(lrf_pkg::KIND_PIN, 63);
		queue_request(lrf_pkg::KIND_NONE, 63);
		queue_request(lrf_pkg::KIND_VICTIM, 63);
		queue_request(lrf_pkg::KIND_UNPIN, 42);
		queue_request(lrf_pkg::KIND_PIN, 42);
		queue_request(lrf_pkg::KIND_PIN, 21);
		queue_request(lrf_pkg::KIND_VICTIM, 0);
		queue_request(lrf_pkg::KIND_UNPIN, 63);
		queue_request(lrf_pkg::KIND_UNPIN, 1);
		queue_request(lrf_pkg::KIND_PIN, 63);
		queue_request(lrf_pkg::KIND_VICTIM, 0);
		queue_request(lrf_pkg::KIND_VICTIM, 63);
		queue_request(lrf_pkg::KIND_NONE, 0);
		queue_request(lrf_pkg::KIND_PIN, 0);
		drain_backlog();

		// Full rate on both sides
		add_random_requests(500);
		drain_backlog();

		// Sparse requests
		send_idle_pct = 87;
		add_random_requests(350);
		drain_backlog();

		// Slow result side
		send_idle_pct  = 0;
		recv_stall_pct = 87;
		add_random_requests(350);
		drain_backlog();

		// Light jitter on both sides
		send_idle_pct  = 11;
		recv_stall_pct = 11;
		add_random_requests(450);
		drain_backlog();

		// Hold the result side off long enough to back up the request side
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		add_random_requests(300);
		hold_left = 400;
		drain_backlog();

		while (s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- lru_frame_replacer_unit.f -----
src/lrf_pkg.sv
src/lrf_ctrl.sv
src/lrf_datapath.sv
src/lru_frame_replacer_unit.sv
src/lrf_checker.sv
verif/tb_lru_frame_replacer_unit.sv
